// ----- src/gbi_pkg.sv -----
// Shared types and constants of the grid bicubic interpolator.
package gbi_pkg;

    // Fixed field widths
    localparam int SAMPLE_W = 32;
    localparam int POS_W    = 20;
    localparam int IDX_W    = 4;
    localparam int PTS_W    = 5;

    // Cubic operand width: samples plus headroom for exact first-pass results
    localparam int OPND_W   = SAMPLE_W + 3;

    // Item opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register indexes
    localparam logic REG_POINTS_A4 = 1'b0;
    localparam logic REG_POINTS_A5 = 1'b1;

    localparam logic [PTS_W-1:0] PTS_RESET = 5'd13;

    // Saturation limits of the result
    localparam logic [SAMPLE_W-1:0] W_MAX = 32'h7fff_ffff;
    localparam logic [SAMPLE_W-1:0] W_MIN = 32'h8000_0000;

    // Top-level sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ROW_GO,
        ST_ROW_WAIT,
        ST_COL_GO,
        ST_COL_WAIT,
        ST_DONE
    } t_gbi_state;

    // Cubic unit steps
    typedef enum logic [2:0] {
        CUB_IDLE,
        CUB_MUL3,
        CUB_MUL2,
        CUB_MUL1,
        CUB_SUM
    } t_cub_state;

endpackage

// ----- src/gbi_grid_mem.sv -----
// Sample store: one write port, one read port with registered read data.
module gbi_grid_mem import gbi_pkg::*; #(
    parameter int DEPTH = 256,
    parameter int DW    = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/gbi_cubic_unit.sv -----
// Catmull-Rom cubic over four points, Horner form on one shared multiplier.
module gbi_cubic_unit import gbi_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [OPND_W-1:0]    i_p0,
    input  logic signed [OPND_W-1:0]    i_p1,
    input  logic signed [OPND_W-1:0]    i_p2,
    input  logic signed [OPND_W-1:0]    i_p3,
    input  logic [FRAC_BITS-1:0]        i_x,
    output logic                        o_done,
    output logic signed [OPND_W-1:0]    o_result
);

    // Coefficient and product widths
    localparam int CW  = OPND_W + 5;
    localparam int PRW = CW + FRAC_BITS + 1;
    localparam logic signed [PRW-1:0] HALF_P = PRW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PRW-1:0] ONE_P  = PRW'(1) <<< FRAC_BITS;

    t_cub_state r_state, n_state;

    logic signed [CW-1:0]     e0, e1, e2, e3, d12;
    logic signed [CW-1:0]     c1, c2, c3;
    logic signed [CW-1:0]     r_c1, r_c2, r_c3;
    logic signed [OPND_W-1:0] r_p1;
    logic [FRAC_BITS-1:0]     r_x;
    logic signed [PRW-1:0]    r_prod;
    logic signed [OPND_W-1:0] r_res;
    logic                     r_done;

    logic signed [CW-1:0]      rnd;
    logic signed [OPND_W-1:0]  t_last;
    logic signed [CW-1:0]      mul_a;
    logic signed [FRAC_BITS:0] x_s;
    logic signed [PRW-1:0]     prod;
    logic                      prod_en;

    // Exact coefficients from the operands
    always_comb begin
        e0  = CW'(i_p0);
        e1  = CW'(i_p1);
        e2  = CW'(i_p2);
        e3  = CW'(i_p3);
        d12 = e1 - e2;
        c1  = e2 - e0;
        c2  = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
        c3  = (d12 <<< 1) + d12 + e3 - e0;
    end

    // Round to nearest, ties up, of the previous product
    assign rnd    = CW'((r_prod + HALF_P) >>> FRAC_BITS);
    assign t_last = OPND_W'((r_prod + ONE_P) >>> (FRAC_BITS + 1));

    assign x_s  = signed'({1'b0, r_x});
    assign prod = PRW'(mul_a) * PRW'(x_s);

    // Next step
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CUB_IDLE: if (i_start) n_state = CUB_MUL3;
            CUB_MUL3: n_state = CUB_MUL2;
            CUB_MUL2: n_state = CUB_MUL1;
            CUB_MUL1: n_state = CUB_SUM;
            CUB_SUM:  n_state = CUB_IDLE;
            default:  n_state = CUB_IDLE;
        endcase
    end

    // Multiplier operand per step
    always_comb begin
        mul_a   = '0;
        prod_en = 1'b0;
        unique case (r_state)
            CUB_IDLE: begin
                prod_en = 1'b0;
            end
            CUB_MUL3: begin
                mul_a   = r_c3;
                prod_en = 1'b1;
            end
            CUB_MUL2: begin
                mul_a   = rnd + r_c2;
                prod_en = 1'b1;
            end
            CUB_MUL1: begin
                mul_a   = rnd + r_c1;
                prod_en = 1'b1;
            end
            CUB_SUM: begin
                prod_en = 1'b0;
            end
            default: begin
                prod_en = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CUB_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == CUB_SUM);
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == CUB_IDLE && i_start) begin
            r_c1 <= c1;
            r_c2 <= c2;
            r_c3 <= c3;
            r_p1 <= i_p1;
            r_x  <= i_x;
        end
        if (prod_en) begin
            r_prod <= prod;
        end
        if (r_state == CUB_SUM) begin
            r_res <= r_p1 + t_last;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == CUB_IDLE)
        else $error("cubic unit started while busy");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_state == CUB_MUL3)
        else $error("cubic unit did not begin after start");

    a_done_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state) == CUB_SUM)
        else $error("cubic done without a final sum");
`endif

endmodule

// ----- src/grid_bicubic_interpolator.sv -----
// Top level: grid store, 4x4 fetch sequencer and two-pass bicubic evaluation.
//
//  Channel  Signals                                    Direction
//  in       i_in_valid / o_in_stall, item fields       in
//  out      o_out_valid / i_out_stall, o_weight, flag  out
//  cfg      i_cfg_we, i_cfg_idx, i_cfg_data            in
//
// A load is written straight into the grid store and leaves the block idle. An
// in-range query streams 16 samples out of the single read port, runs five cubics
// on one shared multiplier, hands the result to the output register and returns to
// idle; no new item is taken before then. An out-of-range query goes straight to the hand-off.
// Synchronous active-low reset clears control and sets both point counts to 13.
// A stalled result waits in the output register; a new item is taken meanwhile,
// and the next result waits for that register to free.
module grid_bicubic_interpolator import gbi_pkg::*; #(
    parameter int GRID_POINTS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // item input
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_opcode,
    input  logic [IDX_W-1:0]           i_row_index,
    input  logic [IDX_W-1:0]           i_col_index,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  logic [POS_W-1:0]           i_pos_a4,
    input  logic [POS_W-1:0]           i_pos_a5,
    // result output
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_weight,
    output logic                       o_in_range,
    // configuration
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [PTS_W-1:0]           i_cfg_data
);

    localparam int CELLS = GRID_POINTS * GRID_POINTS;
    localparam int AW    = $clog2(CELLS);
    localparam int RIW   = $clog2(GRID_POINTS);
    localparam int IAW   = (POS_W > FRAC_BITS) ? (POS_W - FRAC_BITS) : 1;
    localparam int CMPW  = ((IAW > 7) ? IAW : 7) + 2;
    localparam logic [SAMPLE_W-1:0] WEIGHT_ONE = SAMPLE_W'(1) << FRAC_BITS;

    // Axis check: a full 4x4 neighbourhood exists around this index
    function automatic logic axis_ok(input logic [IAW-1:0] ia, input logic [PTS_W-1:0] pts);
        logic [CMPW-1:0] n;
        logic [CMPW-1:0] i3;
        n  = (CMPW'(pts) > CMPW'(GRID_POINTS)) ? CMPW'(GRID_POINTS) : CMPW'(pts);
        i3 = CMPW'(ia) + CMPW'(3);
        return (ia != '0) && (i3 <= n);
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic [SAMPLE_W-1:0] saturate(input logic signed [OPND_W-1:0] v);
        logic [OPND_W-SAMPLE_W:0] top;
        top = v[OPND_W-1:SAMPLE_W-1];
        if (top == '0 || top == '1) begin
            return v[SAMPLE_W-1:0];
        end
        return v[OPND_W-1] ? W_MIN : W_MAX;
    endfunction

    t_gbi_state r_state, n_state;

    logic [PTS_W-1:0]    r_pts_a4, r_pts_a5;
    logic [IAW-1:0]      r_ia, r_ib;
    logic [FRAC_BITS-1:0] r_fa, r_fb;
    logic [4:0]          r_cnt;
    logic [1:0]          r_rcnt;
    logic                r_rd_vld;
    logic signed [SAMPLE_W-1:0] r_line [16];
    logic signed [OPND_W-1:0]   r_rows [4];
    logic [SAMPLE_W-1:0] r_res_weight;
    logic                r_res_flag;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_weight;
    logic                r_out_flag;

    logic                in_ready, in_acc, q_ok;
    logic [IAW-1:0]      ia_now, ib_now;
    logic                load_ok, mem_we, mem_re;
    logic [AW-1:0]       waddr, raddr;
    logic [RIW-1:0]      f_row, f_col;
    logic [SAMPLE_W-1:0] rdata;
    logic                cub_start, cub_done, out_load;
    logic signed [OPND_W-1:0] op0, op1, op2, op3, cub_res;
    logic [FRAC_BITS-1:0] cub_x;

    assign in_acc = i_in_valid && in_ready;

    // Query decode and range check at accept
    assign ia_now = IAW'(i_pos_a4 >> FRAC_BITS);
    assign ib_now = IAW'(i_pos_a5 >> FRAC_BITS);
    assign q_ok   = axis_ok(ia_now, r_pts_a4) && axis_ok(ib_now, r_pts_a5);

    // Load addressing; loads outside the grid are dropped
    assign load_ok = (32'(i_row_index) < 32'(GRID_POINTS))
                  && (32'(i_col_index) < 32'(GRID_POINTS));
    assign mem_we  = in_acc && (i_opcode == OP_LOAD) && load_ok;
    assign waddr   = AW'(AW'(i_row_index) * AW'(GRID_POINTS) + AW'(i_col_index));

    // Fetch addressing: neighbourhood row-major from (ia-1, ib-1)
    assign f_row = RIW'(r_ia) - RIW'(1) + RIW'(r_cnt[3:2]);
    assign f_col = RIW'(r_ib) - RIW'(1) + RIW'(r_cnt[1:0]);
    assign raddr = AW'(AW'(f_row) * AW'(GRID_POINTS) + AW'(f_col));

    gbi_grid_mem #(
        .DEPTH (CELLS),
        .DW    (SAMPLE_W),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (i_sample_value),
        .i_re    (mem_re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Cubic operands: row samples first, then the four row results
    always_comb begin
        if (r_state == ST_COL_GO) begin
            op0   = r_rows[0];
            op1   = r_rows[1];
            op2   = r_rows[2];
            op3   = r_rows[3];
            cub_x = r_fa;
        end else begin
            op0   = OPND_W'(r_line[0]);
            op1   = OPND_W'(r_line[1]);
            op2   = OPND_W'(r_line[2]);
            op3   = OPND_W'(r_line[3]);
            cub_x = r_fb;
        end
    end

    gbi_cubic_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cubic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (cub_start),
        .i_p0     (op0),
        .i_p1     (op1),
        .i_p2     (op2),
        .i_p3     (op3),
        .i_x      (cub_x),
        .o_done   (cub_done),
        .o_result (cub_res)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_opcode == OP_QUERY) begin
                    n_state = q_ok ? ST_FETCH : ST_DONE;
                end
            end
            ST_FETCH:    if (r_cnt[4]) n_state = ST_ROW_GO;
            ST_ROW_GO:   n_state = ST_ROW_WAIT;
            ST_ROW_WAIT: begin
                if (cub_done) begin
                    n_state = (r_rcnt == 2'd3) ? ST_COL_GO : ST_ROW_GO;
                end
            end
            ST_COL_GO:   n_state = ST_COL_WAIT;
            ST_COL_WAIT: if (cub_done) n_state = ST_DONE;
            ST_DONE:     if (out_load) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_ready  = (r_state == ST_IDLE);
        mem_re    = (r_state == ST_FETCH) && !r_cnt[4];
        cub_start = (r_state == ST_ROW_GO) || (r_state == ST_COL_GO);
        out_load  = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    end

    assign o_in_stall = !in_ready;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_pts_a4    <= PTS_RESET;
            r_pts_a5    <= PTS_RESET;
            r_cnt       <= '0;
            r_rcnt      <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= mem_re;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_POINTS_A4: r_pts_a4 <= i_cfg_data;
                    REG_POINTS_A5: r_pts_a5 <= i_cfg_data;
                    default:       r_pts_a4 <= r_pts_a4;
                endcase
            end
            if (in_acc) begin
                r_cnt  <= '0;
                r_rcnt <= '0;
            end else begin
                if (mem_re) begin
                    r_cnt <= r_cnt + 5'd1;
                end
                if (r_state == ST_ROW_WAIT && cub_done) begin
                    r_rcnt <= r_rcnt + 2'd1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // capture the query
        if (in_acc) begin
            r_ia         <= ia_now;
            r_ib         <= ib_now;
            r_fa         <= FRAC_BITS'(i_pos_a4);
            r_fb         <= FRAC_BITS'(i_pos_a5);
            r_res_weight <= WEIGHT_ONE;
            r_res_flag   <= 1'b0;
        end
        // samples stream into the line, first one ends at the head
        if (r_rd_vld) begin
            for (int i = 0; i < 15; i++) begin
                r_line[i] <= r_line[i+1];
            end
            r_line[15] <= rdata;
        end else if (r_state == ST_ROW_WAIT && cub_done) begin
            for (int i = 0; i < 12; i++) begin
                r_line[i] <= r_line[i+4];
            end
        end
        // row results
        if (r_state == ST_ROW_WAIT && cub_done) begin
            for (int i = 0; i < 3; i++) begin
                r_rows[i] <= r_rows[i+1];
            end
            r_rows[3] <= cub_res;
        end
        if (r_state == ST_COL_WAIT && cub_done) begin
            r_res_weight <= saturate(cub_res);
            r_res_flag   <= 1'b1;
        end
        // output register
        if (out_load) begin
            r_out_weight <= r_res_weight;
            r_out_flag   <= r_res_flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_weight    = r_out_weight;
    assign o_in_range  = r_out_flag;

`ifndef NO_ASSERTIONS
    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cub_done |-> (r_state == ST_ROW_WAIT || r_state == ST_COL_WAIT))
        else $error("cubic result arrived outside a wait state");

    a_fetch_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FETCH |-> r_cnt <= 5'd16)
        else $error("fetch counter overran the neighbourhood");

    a_default_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_flag |-> r_out_weight == WEIGHT_ONE)
        else $error("out-of-range result is not 1.0");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_state == ST_IDLE && !r_rd_vld)
        else $error("grid write during a query");
`endif

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench of the grid bicubic interpolator: grid loads, queries, point counts.
`timescale 1ns / 100ps

module testbench;
    import gbi_pkg::*;

    localparam int     GRID_N      = 16;
    localparam int     FRAC        = 16;
    localparam int     SETTLE_CYC  = 64;
    localparam int     CYCLE_LIMIT = 1_000_000;
    localparam longint HALF_LSB    = 64'sd1 <<< (FRAC - 1);
    localparam longint ONE_LSB     = 64'sd1 <<< FRAC;
    localparam longint SAT_HI      = 64'sd2147483647;
    localparam longint SAT_LO      = -64'sd2147483648;

    // One input item, every field carried whether the opcode uses it or not
    typedef struct packed {
        logic                opcode;
        logic [IDX_W-1:0]    row;
        logic [IDX_W-1:0]    col;
        logic [SAMPLE_W-1:0] sample;
        logic [POS_W-1:0]    pos_a4;
        logic [POS_W-1:0]    pos_a5;
    } t_grid_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] weight;
        logic                in_range;
    } t_weight_result;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic                       i_opcode;
    logic [IDX_W-1:0]           i_row_index;
    logic [IDX_W-1:0]           i_col_index;
    logic signed [SAMPLE_W-1:0] i_sample_value;
    logic [POS_W-1:0]           i_pos_a4;
    logic [POS_W-1:0]           i_pos_a5;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [SAMPLE_W-1:0] o_weight;
    logic                       o_in_range;
    logic                       i_cfg_we;
    logic                       i_cfg_idx;
    logic [PTS_W-1:0]           i_cfg_data;

    // Predictor state: grid samples and point counts as the block should hold them
    logic signed [SAMPLE_W-1:0] grid_samples [GRID_N*GRID_N];
    logic [PTS_W-1:0]           pts_a4 = PTS_RESET;
    logic [PTS_W-1:0]           pts_a5 = PTS_RESET;
    t_weight_result             weight_expect_q [$];

    int error_count   = 0;
    int cycle_count   = 0;
    int stall_left    = 0;
    int in_gap_pct    = 0;
    int out_stall_pct = 0;

    grid_bicubic_interpolator #(
        .GRID_POINTS (GRID_N),
        .FRAC_BITS   (FRAC)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_row_index    (i_row_index),
        .i_col_index    (i_col_index),
        .i_sample_value (i_sample_value),
        .i_pos_a4       (i_pos_a4),
        .i_pos_a5       (i_pos_a5),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_weight       (o_weight),
        .o_in_range     (o_in_range),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL grid_bicubic_interpolator");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One Catmull-Rom cubic at fraction x, rounding half up at each step
    function automatic longint catmull_rom(longint p0, longint p1, longint p2, longint p3,
                                           longint x);
        longint c1, c2, c3, t;
        c1 = p2 - p0;
        c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c3 = 3 * (p1 - p2) + p3 - p0;
        t  = (c3 * x + HALF_LSB) >>> FRAC;
        t  = ((t + c2) * x + HALF_LSB) >>> FRAC;
        t  = ((t + c1) * x + ONE_LSB) >>> (FRAC + 1);
        return p1 + t;
    endfunction

    function automatic int points_in_use(logic [PTS_W-1:0] pts);
        return (pts > GRID_N) ? GRID_N : int'(pts);
    endfunction

    // A full 4x4 neighborhood needs one point below and two above
    function automatic bit axis_in_range(int idx, int n);
        return idx >= 1 && idx + 3 <= n;
    endfunction

    function automatic t_weight_result bicubic_weight(logic [POS_W-1:0] pa,
                                                      logic [POS_W-1:0] pb);
        t_weight_result res;
        int             ia, ib, k, c;
        longint         fa, fb, acc;
        longint         line [4];
        longint         rows [4];
        ia = int'(pa[POS_W-1:FRAC]);
        ib = int'(pb[POS_W-1:FRAC]);
        fa = longint'(pa[FRAC-1:0]);
        fb = longint'(pb[FRAC-1:0]);
        if (!axis_in_range(ia, points_in_use(pts_a4)) ||
            !axis_in_range(ib, points_in_use(pts_a5))) begin
            res.weight   = SAMPLE_W'(ONE_LSB);
            res.in_range = 1'b0;
            return res;
        end
        // second axis first, row by row, then the first axis over the rows
        for (k = 0; k < 4; k++) begin
            for (c = 0; c < 4; c++)
                line[c] = longint'(grid_samples[(ia - 1 + k) * GRID_N + ib - 1 + c]);
            rows[k] = catmull_rom(line[0], line[1], line[2], line[3], fb);
        end
        acc = catmull_rom(rows[0], rows[1], rows[2], rows[3], fa);
        if (acc > SAT_HI)
            acc = SAT_HI;
        else if (acc < SAT_LO)
            acc = SAT_LO;
        res.weight   = SAMPLE_W'(acc);
        res.in_range = 1'b1;
        return res;
    endfunction

    // Update the grid copy or queue the expected weight of an accepted item
    function automatic void apply_item(t_grid_item it);
        if (it.opcode == OP_LOAD)
            grid_samples[{it.row, it.col}] = it.sample;
        else
            weight_expect_q.insert(weight_expect_q.size(),
                                   bicubic_weight(it.pos_a4, it.pos_a5));
    endfunction

    // ------------------------------------------------------------------
    // Item construction
    // ------------------------------------------------------------------

    function automatic logic [POS_W-1:0] grid_pos(int idx, logic [FRAC-1:0] frac);
        return {idx[IDX_W-1:0], frac};
    endfunction

    function automatic t_grid_item make_load(int row, int col, logic [SAMPLE_W-1:0] value);
        t_grid_item it;
        it.opcode = OP_LOAD;
        it.row    = row[IDX_W-1:0];
        it.col    = col[IDX_W-1:0];
        it.sample = value;
        it.pos_a4 = POS_W'($urandom_range(0, 2**POS_W - 1));
        it.pos_a5 = POS_W'($urandom_range(0, 2**POS_W - 1));
        return it;
    endfunction

    function automatic t_grid_item make_query(logic [POS_W-1:0] pa, logic [POS_W-1:0] pb);
        t_grid_item it;
        it.opcode = OP_QUERY;
        it.row    = IDX_W'($urandom_range(0, GRID_N - 1));
        it.col    = IDX_W'($urandom_range(0, GRID_N - 1));
        it.sample = $urandom;
        it.pos_a4 = pa;
        it.pos_a5 = pb;
        return it;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return W_MAX;
            1:       return W_MIN;
            2:       return '0;
            3, 4:    return $urandom;
            default: return $urandom_range(0, 32'h01ff_ffff) - 32'h0100_0000;
        endcase
    endfunction

    function automatic logic [FRAC-1:0] pick_frac();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 16'h8000;
            3:       return 16'h0001;
            default: return FRAC'($urandom_range(0, 2**FRAC - 1));
        endcase
    endfunction

    function automatic logic [PTS_W-1:0] pick_points();
        case ($urandom_range(0, 7))
            0:       return 5'd4;
            1:       return 5'd16;
            2:       return PTS_RESET;
            3:       return PTS_W'($urandom_range(17, 31));
            4:       return PTS_W'($urandom_range(0, 3));
            default: return PTS_W'($urandom_range(4, 16));
        endcase
    endfunction

    // Mostly well-formed queries inside the current grid, some loads and noise
    function automatic t_grid_item random_item();
        int n4, n5;
        n4 = points_in_use(pts_a4);
        n5 = points_in_use(pts_a5);
        if ($urandom_range(1, 100) <= 25)
            return make_load($urandom_range(0, GRID_N - 1), $urandom_range(0, GRID_N - 1),
                             pick_sample());
        if (n4 >= 4 && n5 >= 4 && $urandom_range(1, 100) <= 85)
            return make_query(grid_pos($urandom_range(1, n4 - 3), pick_frac()),
                              grid_pos($urandom_range(1, n5 - 3), pick_frac()));
        return make_query(POS_W'($urandom_range(0, 2**POS_W - 1)),
                          POS_W'($urandom_range(0, 2**POS_W - 1)));
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Send one item, with an optional idle burst ahead of it
    task automatic send_item(input t_grid_item it);
        if ($urandom_range(1, 100) <= in_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= it.opcode;
        i_row_index    <= it.row;
        i_col_index    <= it.col;
        i_sample_value <= it.sample;
        i_pos_a4       <= it.pos_a4;
        i_pos_a5       <= it.pos_a5;
        do @(posedge i_clk); while (o_in_stall);
        apply_item(it);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (weight_expect_q.size() != 0);
    endtask

    // Point counts change only with the block idle
    task automatic set_points(input logic [PTS_W-1:0] a4, input logic [PTS_W-1:0] a5);
        wait_for_results();
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_POINTS_A4;
        i_cfg_data <= a4;
        @(posedge i_clk);
        i_cfg_idx  <= REG_POINTS_A5;
        i_cfg_data <= a5;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pts_a4 = a4;
        pts_a5 = a5;
        @(posedge i_clk);
    endtask

    // Result side backpressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(1, 100) <= out_stall_pct) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 14);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest expected weight
    always @(posedge i_clk) begin : check_weight
        t_weight_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (weight_expect_q.size() == 0) begin
                $display("%0t: unexpected result: weight %h in_range %b",
                         $time, o_weight, o_in_range);
                error_count = error_count + 1;
            end else begin
                want = weight_expect_q.pop_front();
                if (o_weight !== want.weight) begin
                    $display("%0t: weight mismatch: expected %h actual %h",
                             $time, want.weight, o_weight);
                    error_count = error_count + 1;
                end
                if (o_in_range !== want.in_range) begin
                    $display("%0t: in_range mismatch: expected %b actual %b",
                             $time, want.in_range, o_in_range);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Positions without a full neighborhood, before any sample is loaded
    task automatic test_out_of_range();
        send_item(make_query(grid_pos(0, 16'h0000), grid_pos(0, 16'h0000)));
        send_item(make_query('1, '1));
        send_item(make_query(grid_pos(10, 16'h0000), grid_pos(11, 16'h0000)));
        send_item(make_query(grid_pos(11, 16'hffff), grid_pos(1, 16'h0000)));
        send_item(make_query(grid_pos(1, 16'h8000), grid_pos(0, 16'hffff)));
        send_item(make_query(grid_pos(15, 16'h0001), grid_pos(5, 16'h4000)));
    endtask

    // Overshoot past both ends of the signed range, plus exact grid points
    task automatic test_saturation();
        int r, c;
        for (r = 0; r < 4; r++)
            for (c = 0; c < 4; c++)
                send_item(make_load(r, c, ((r == 1 || r == 2) && (c == 1 || c == 2)) ?
                                          W_MAX : '0));
        send_item(make_query(grid_pos(1, 16'h8000), grid_pos(1, 16'h8000)));
        send_item(make_query(grid_pos(1, 16'h0000), grid_pos(1, 16'h0000)));
        send_item(make_query(grid_pos(1, 16'hffff), grid_pos(1, 16'hffff)));
        send_item(make_query(grid_pos(1, 16'h0000), grid_pos(1, 16'h8000)));
        // inner block to the most negative value
        for (r = 1; r < 3; r++)
            for (c = 1; c < 3; c++)
                send_item(make_load(r, c, W_MIN));
        send_item(make_query(grid_pos(1, 16'h8000), grid_pos(1, 16'h8000)));
        send_item(make_query(grid_pos(1, 16'h4000), grid_pos(1, 16'hc000)));
    endtask

    // Every cell loaded once, in shuffled order
    task automatic test_grid_fill();
        int order [GRID_N*GRID_N];
        int k, j, tmp;
        for (k = 0; k < GRID_N * GRID_N; k++)
            order[k] = k;
        for (k = GRID_N * GRID_N - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (k = 0; k < GRID_N * GRID_N; k++)
            send_item(make_load(order[k] / GRID_N, order[k] % GRID_N, pick_sample()));
    endtask

    // Edges of the usable range at the extreme point counts
    task automatic test_points_extremes();
        // smallest grid: index 1 only
        set_points(5'd4, 5'd4);
        send_item(make_query(grid_pos(1, 16'hffff), grid_pos(1, 16'h0000)));
        send_item(make_query(grid_pos(2, 16'h0000), grid_pos(1, 16'h8000)));
        send_item(make_query(grid_pos(1, 16'h1234), grid_pos(2, 16'h0000)));
        // full grid: the far neighbor is the last cell
        set_points(5'd16, 5'd16);
        send_item(make_query(grid_pos(13, 16'hffff), grid_pos(13, 16'hffff)));
        send_item(make_query(grid_pos(14, 16'h0000), grid_pos(13, 16'h0000)));
        send_item(make_query(grid_pos(13, 16'h0000), grid_pos(14, 16'h0000)));
        // counts above the grid size clamp to it
        set_points(5'd31, 5'd17);
        send_item(make_query(grid_pos(13, 16'h8000), grid_pos(13, 16'h0001)));
        send_item(make_query(grid_pos(14, 16'h8000), grid_pos(2, 16'h0001)));
        // counts below four leave nothing in range
        set_points(5'd0, 5'd3);
        send_item(make_query(grid_pos(1, 16'h0000), grid_pos(1, 16'h0000)));
        send_item(make_query(grid_pos(1, 16'h8000), grid_pos(0, 16'h8000)));
        // unequal axes
        set_points(5'd16, 5'd4);
        send_item(make_query(grid_pos(13, 16'h7fff), grid_pos(1, 16'h8001)));
        send_item(make_query(grid_pos(1, 16'h0000), grid_pos(2, 16'h0000)));
        set_points(PTS_RESET, PTS_RESET);
        send_item(make_query(grid_pos(10, 16'hffff), grid_pos(10, 16'h0000)));
        send_item(make_query(grid_pos(11, 16'h0000), grid_pos(10, 16'h0000)));
    endtask

    // Random phases, each under its own point counts and idling mix
    task automatic test_random();
        int phase, k;
        for (phase = 0; phase < 8; phase++) begin
            set_points(pick_points(), pick_points());
            in_gap_pct    = (phase % 4 == 3) ? 0 : $urandom_range(5, 40);
            out_stall_pct = (phase % 4 == 2) ? 0 : $urandom_range(2, 25);
            for (k = 0; k < 120; k++) begin
                // hold the sender until the pipeline is empty
                if (phase == 1 && k == 60)
                    wait_for_results();
                send_item(random_item());
            end
        end
    endtask

    // Back-to-back items with no idling on either side
    task automatic test_streaming();
        int k;
        in_gap_pct    = 0;
        out_stall_pct = 0;
        set_points(5'd16, 5'd16);
        for (k = 0; k < 150; k++)
            send_item(random_item());
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_opcode       <= OP_LOAD;
        i_row_index    <= '0;
        i_col_index    <= '0;
        i_sample_value <= '0;
        i_pos_a4       <= '0;
        i_pos_a5       <= '0;
        i_out_stall    <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= REG_POINTS_A4;
        i_cfg_data     <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_gap_pct    = 20;
        out_stall_pct = 15;
        test_out_of_range();
        test_saturation();
        test_grid_fill();
        test_points_extremes();
        test_random();
        test_streaming();

        wait_for_results();
        repeat (SETTLE_CYC) @(posedge i_clk);
        error_count = error_count + weight_expect_q.size();
        if (error_count == 0)
            $display("PASS grid_bicubic_interpolator");
        else
            $display("FAIL grid_bicubic_interpolator");
        $finish;
    end

endmodule

// ----- sim.f -----
src/gbi_pkg.sv
src/gbi_grid_mem.sv
src/gbi_cubic_unit.sv
src/grid_bicubic_interpolator.sv
dv/testbench.sv
